// ===== hdl/ecc_pkg.sv =====
package ecc_pkg;

    localparam int ACC_W      = 64;
    localparam int ENERGY_W   = 63;
    localparam int ITER_W     = 16;
    localparam int STATUS_W   = 3;
    localparam int REG_IDX_W  = 2;
    localparam int CFG_DATA_W = 63;
    localparam int MID_DEPTH  = 4;
    localparam int OUT_DEPTH  = 8;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_ELEM  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_CONTINUE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CONVERGED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_GAVE_UP     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FAILED      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_STARTED = 3'd4;

    localparam logic [REG_IDX_W-1:0] REG_TOLERANCE     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_TOLERANCE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_ITER      = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_GO_ON         = 2'd3;

    localparam logic [ITER_W-1:0] ITER_MAX = '1;

    typedef struct packed {
        logic              mode;
        logic              last;
        logic [ACC_W-1:0]  prod;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ITER_W-1:0]   iteration;
        logic [ENERGY_W-1:0] energy;
    } result_t;

    typedef struct packed {
        logic [ENERGY_W-1:0] tolerance;
        logic [ENERGY_W-1:0] max_tolerance;
        logic [ITER_W-1:0]   max_iterations;
        logic                go_on;
    } cfg_t;

endpackage

// ===== hdl/ecc_fifo.sv =====
module ecc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             din,
    output logic                         full,
    input  logic                         pop,
    output logic [WIDTH-1:0]             dout,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign dout    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/ecc_front.sv =====
module ecc_front import ecc_pkg::*; #(
    parameter int ELEM_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         mode,
    input  logic signed [ELEM_WIDTH-1:0] disp_incr,
    input  logic signed [ELEM_WIDTH-1:0] resid,
    input  logic                         last_elem,
    input  logic                         q_full,
    output logic                         q_push,
    output entry_t                       q_din
);

    logic signed [2*ELEM_WIDTH-1:0] prod;
    logic signed [ACC_W-1:0]        prod_ext;
    logic                           valid_reg;
    entry_t                         entry_reg;
    logic                           accept;
    logic                           fwd;

    assign prod     = disp_incr * resid;
    assign prod_ext = ACC_W'(prod);

    // The front register hands its transaction on whenever the queue has room.
    assign fwd    = valid_reg && !q_full;
    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = fwd;
    assign q_din  = entry_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg.mode <= mode;
            entry_reg.last <= last_elem;
            entry_reg.prod <= prod_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept || (valid_reg && !fwd);
        end
    end

endmodule

// ===== hdl/ecc_back.sv =====
module ecc_back import ecc_pkg::*; (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cfg_t                           cfg,
    input  logic                           q_empty,
    input  entry_t                         q_dout,
    output logic                           q_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
    output logic                           out_push,
    output result_t                        out_data
);

    localparam int CNT_W = $clog2(OUT_DEPTH+1);

    logic [ACC_W-1:0]    accum_reg;
    logic [ACC_W:0]      sum_wide;
    logic [ACC_W-1:0]    sum_sat;
    logic [CNT_W:0]      in_flight;
    logic                pop_ok;

    logic                s1_valid_reg;
    logic                s1_start_reg;
    logic [ACC_W-1:0]    s1_sum_reg;
    logic [ACC_W-1:0]    mag;

    logic                s2_valid_reg;
    logic                s2_start_reg;
    logic [ENERGY_W-1:0] s2_energy_reg;

    logic                s3_valid_reg;
    logic                s3_start_reg;
    logic [ENERGY_W-1:0] s3_energy_reg;
    logic                s3_le_tol_reg;
    logic                s3_gt_max_reg;

    logic [ITER_W-1:0]   iter_reg;
    logic [ITER_W-1:0]   iter_next;
    logic                exhausted;
    result_t             res;

    // Results still in the pipeline are counted against free space in the
    // output queue, so the stages never need to stall.
    assign in_flight = (CNT_W+1)'(out_count) + (CNT_W+1)'(s1_valid_reg)
                     + (CNT_W+1)'(s2_valid_reg) + (CNT_W+1)'(s3_valid_reg);
    assign pop_ok    = !q_empty && (in_flight < (CNT_W+1)'(OUT_DEPTH));
    assign q_pop     = pop_ok;

    assign sum_wide = {accum_reg[ACC_W-1], accum_reg} + {q_dout.prod[ACC_W-1], q_dout.prod};

    always_comb
    begin
        sum_sat = sum_wide[ACC_W-1:0];
        if (sum_wide[ACC_W] != sum_wide[ACC_W-1])
        begin
            sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= pop_ok && (q_dout.mode == MODE_START || q_dout.last);
            if (pop_ok)
            begin
                if (q_dout.mode == MODE_START || q_dout.last)
                begin
                    accum_reg <= '0;
                end
                else
                begin
                    accum_reg <= sum_sat;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_ok)
        begin
            s1_start_reg <= (q_dout.mode == MODE_START);
            s1_sum_reg   <= sum_sat;
        end
    end

    // The most negative sum has magnitude 2^63, which still halves into 63 bits.
    assign mag = s1_sum_reg[ACC_W-1] ? (~s1_sum_reg + 1'b1) : s1_sum_reg;

    always_ff @(posedge clk)
    begin
        s2_start_reg  <= s1_start_reg;
        s2_energy_reg <= mag[ACC_W-1:1];
        s3_start_reg  <= s2_start_reg;
        s3_energy_reg <= s2_energy_reg;
        s3_le_tol_reg <= (s2_energy_reg <= cfg.tolerance);
        s3_gt_max_reg <= (s2_energy_reg > cfg.max_tolerance);
    end

    assign exhausted = (iter_reg >= cfg.max_iterations);

    always_comb
    begin
        iter_next     = iter_reg;
        res.status    = ST_CONTINUE;
        res.iteration = iter_reg;
        res.energy    = s3_energy_reg;
        if (s3_start_reg)
        begin
            iter_next = ITER_W'(1);
        end
        else if (iter_reg == '0)
        begin
            res.status = ST_NOT_STARTED;
            res.energy = '0;
        end
        else if (s3_le_tol_reg)
        begin
            res.status = ST_CONVERGED;
        end
        else if (cfg.go_on && exhausted)
        begin
            res.status = ST_GAVE_UP;
        end
        else
        begin
            res.status = (exhausted || s3_gt_max_reg) ? ST_FAILED : ST_CONTINUE;
            if (iter_reg != ITER_MAX)
            begin
                iter_next = iter_reg + 1'b1;
            end
        end
    end

    assign out_push = s3_valid_reg && !s3_start_reg;
    assign out_data = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            iter_reg     <= '0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (s3_valid_reg)
            begin
                iter_reg <= iter_next;
            end
        end
    end

endmodule

// ===== hdl/energy_increment_convergence_check.sv =====
// Energy-increment convergence check for a Newton-type solver.
// Input channel: a transaction is taken on a rising edge with push high and
// full low. mode 0 starts a new solve (iteration count 1, sum cleared);
// mode 1 carries one increment/residual pair, and last_elem closes the vector.
// Result channel: one result per closing pair, shown while empty is low and
// taken on a rising edge with pop high. Configuration: a write with wr_en high
// sets register wr_index from wr_data on that edge.
// Throughput is one transaction per cycle while full stays low, set by the
// single 32x32 multiplier in the front register and the one accumulate per
// cycle in the back end. An accepted closing pair reaches empty going low
// through the multiply register, the four-entry queue, the accumulate,
// magnitude and compare stages, then the eight-entry output queue.
// When the receiver stalls, the output queue fills; the back end stops taking
// from the middle queue once its results could no longer fit, then the middle
// queue and the front register fill and full rises.
// Reset clears all queues, the sum and the iteration count (not started), and
// loads the registers with their defaults (max_tolerance all ones).
module energy_increment_convergence_check import ecc_pkg::*; #(
    parameter int ELEM_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [REG_IDX_W-1:0]         wr_index,
    input  logic [CFG_DATA_W-1:0]        wr_data,
    input  logic                         push,
    output logic                         full,
    input  logic                         mode,
    input  logic signed [ELEM_WIDTH-1:0] disp_incr,
    input  logic signed [ELEM_WIDTH-1:0] resid,
    input  logic                         last_elem,
    output logic                         empty,
    input  logic                         pop,
    output logic [STATUS_W-1:0]          status,
    output logic [ITER_W-1:0]            iteration,
    output logic [ENERGY_W-1:0]          energy
);

    localparam int MID_CNT_W = $clog2(MID_DEPTH+1);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH+1);

    cfg_t                 cfg_reg;
    logic                 q_full;
    logic                 q_push;
    entry_t               q_din;
    logic                 q_empty;
    logic                 q_pop;
    entry_t               q_dout;
    logic [MID_CNT_W-1:0] q_count;
    logic                 out_push;
    result_t              out_data;
    logic                 out_full;
    result_t              out_dout;
    logic [OUT_CNT_W-1:0] out_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tolerance      <= '0;
            cfg_reg.max_tolerance  <= '1;
            cfg_reg.max_iterations <= '0;
            cfg_reg.go_on          <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_TOLERANCE:     cfg_reg.tolerance      <= wr_data;
                REG_MAX_TOLERANCE: cfg_reg.max_tolerance  <= wr_data;
                REG_MAX_ITER:      cfg_reg.max_iterations <= wr_data[ITER_W-1:0];
                REG_GO_ON:         cfg_reg.go_on          <= wr_data[0];
                default:           cfg_reg                <= cfg_reg;
            endcase
        end
    end

    ecc_front #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .disp_incr (disp_incr),
        .resid     (resid),
        .last_elem (last_elem),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_din     (q_din)
    );

    ecc_fifo #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty),
        .count (q_count)
    );

    ecc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_dout    (q_dout),
        .q_pop     (q_pop),
        .out_count (out_count),
        .out_push  (out_push),
        .out_data  (out_data)
    );

    ecc_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (out_data),
        .full  (out_full),
        .pop   (pop),
        .dout  (out_dout),
        .empty (empty),
        .count (out_count)
    );

    assign status    = out_dout.status;
    assign iteration = out_dout.iteration;
    assign energy    = out_dout.energy;

endmodule

// ===== hdl/ecc_checker.sv =====
module ecc_checker import ecc_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input logic [STATUS_W-1:0] status,
    input logic [ITER_W-1:0]   iteration,
    input logic [ENERGY_W-1:0] energy
);

    // Both queues come out of reset empty.
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> empty && !full)
        else $error("queues not idle during reset");

    // A test before any start carries a zero count and zero energy.
    a_not_started: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && status == ST_NOT_STARTED |-> iteration == '0 && energy == '0)
        else $error("not-started result with nonzero fields");

    // Any decided status belongs to a started solve, so its count is nonzero.
    a_started_count: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && status != ST_NOT_STARTED |-> iteration != '0)
        else $error("decided status with zero iteration count");

    // A result that is not taken stays on the ports unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(status) && $stable(iteration) && $stable(energy))
        else $error("stalled result changed");

endmodule

bind energy_increment_convergence_check ecc_checker u_ecc_checker (.*);
